/* src/cld_pkg.sv */
// Package for the console line discipline: payload types, codes and constants.
package cld_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
    logic [5:0] read_limit;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [5:0] read_length;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic echo_enable;
    logic canonical_enable;
    logic signal_enable;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ECHO,
    S_RAW,
    S_RD,
    S_DLV
  } seq_state_t;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_DRY  = 1'b1;

  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [1:0] REG_ECHO   = 2'd0;
  localparam logic [1:0] REG_CANON  = 2'd1;
  localparam logic [1:0] REG_SIGNAL = 2'd2;

  localparam logic [7:0] CH_INTR  = 8'd3;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DEL   = 8'd127;

endpackage

/* src/cld_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module cld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/cld_seq.sv */
// Line editing sequencer: fill count, RAM access, result generation and output register.
module cld_seq
  import cld_pkg::*;
#(
  parameter int LINE_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  localparam int FW = $clog2(LINE_DEPTH + 1);
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam logic [FW-1:0] DEPTH_F = FW'(LINE_DEPTH);
  localparam logic [5:0]    DEPTH6  = 6'(LINE_DEPTH);

  seq_state_t state, state_next;

  logic [FW-1:0] fill, fill_next;
  logic [FW-1:0] len, len_next;
  logic [FW-1:0] rd_idx, rd_idx_next;
  logic [7:0]    byte_q, byte_q_next;
  logic [1:0]    echo_idx, echo_idx_next;
  logic [1:0]    echo_last, echo_last_next;
  logic          erase, erase_next;
  logic          raw, raw_next;
  logic          dlv, dlv_next;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  logic          emit;
  out_item_t     emit_item;
  logic          load;
  logic          out_free;

  logic [7:0]    cmap;
  logic [5:0]    lim;
  logic [FW-1:0] fill_add;
  logic [FW-1:0] rd_inc;
  logic          deliver;

  cld_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign item_ready = (state == S_IDLE);
  assign out_free   = !result_valid || result_ready;
  assign load       = emit && out_free;
  assign rd_inc     = rd_idx + FW'(1);

  always_comb begin
    cmap = (item.rx_byte == CH_CR) ? CH_LF : item.rx_byte;
    lim  = (item.read_limit == 6'd0) ? 6'd1 : item.read_limit;
    if (lim > DEPTH6) begin
      lim = DEPTH6;
    end
    fill_add = (fill < DEPTH_F) ? fill + FW'(1) : fill;
    deliver  = (cmap == CH_LF) || (7'(fill_add) >= 7'(lim));
  end

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    len_next       = len;
    rd_idx_next    = rd_idx;
    byte_q_next    = byte_q;
    echo_idx_next  = echo_idx;
    echo_last_next = echo_last;
    erase_next     = erase;
    raw_next       = raw;
    dlv_next       = dlv;
    we             = 1'b0;
    waddr          = fill[AW-1:0];
    wdata          = cmap;
    re             = 1'b0;
    raddr          = rd_idx[AW-1:0];
    emit           = 1'b0;
    emit_item      = '0;

    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          echo_idx_next = 2'd0;
          rd_idx_next   = '0;
          raw_next      = 1'b0;
          dlv_next      = 1'b0;
          erase_next    = 1'b0;
          priority if (item.op == OP_DRY) begin
            if (fill != '0) begin
              len_next   = fill;
              fill_next  = '0;
              state_next = S_RD;
            end
          end else if (!cfg.canonical_enable) begin
            byte_q_next    = item.rx_byte;
            raw_next       = 1'b1;
            echo_last_next = 2'd0;
            state_next     = cfg.echo_enable ? S_ECHO : S_RAW;
          end else if (item.rx_byte == CH_INTR && cfg.signal_enable) begin
            state_next = S_IDLE;
          end else if (item.rx_byte == CH_BS || item.rx_byte == CH_DEL) begin
            if (fill != '0) begin
              fill_next = fill - FW'(1);
              if (cfg.echo_enable) begin
                erase_next     = 1'b1;
                echo_last_next = 2'd2;
                state_next     = S_ECHO;
              end
            end
          end else begin
            byte_q_next    = cmap;
            echo_last_next = 2'd0;
            we             = (fill < DEPTH_F);
            if (deliver) begin
              len_next  = fill_add;
              fill_next = '0;
              dlv_next  = 1'b1;
            end else begin
              fill_next = fill_add;
            end
            if (cfg.echo_enable) begin
              state_next = S_ECHO;
            end else if (deliver) begin
              state_next = S_RD;
            end
          end
        end
      end
      S_ECHO: begin
        emit                  = 1'b1;
        emit_item.kind        = KIND_ECHO;
        emit_item.data        = !erase ? byte_q : (echo_idx == 2'd1) ? CH_SPACE : CH_BS;
        emit_item.read_length = 6'd0;
        emit_item.last        = (echo_idx == echo_last) && !raw && !dlv;
        if (load) begin
          if (echo_idx == echo_last) begin
            priority if (raw) begin
              state_next = S_RAW;
            end else if (dlv) begin
              state_next = S_RD;
            end else begin
              state_next = S_IDLE;
            end
          end else begin
            echo_idx_next = echo_idx + 2'd1;
          end
        end
      end
      S_RAW: begin
        emit                  = 1'b1;
        emit_item.kind        = KIND_READ;
        emit_item.data        = byte_q;
        emit_item.read_length = 6'd1;
        emit_item.last        = 1'b1;
        if (load) begin
          state_next = S_IDLE;
        end
      end
      S_RD: begin
        re         = 1'b1;
        state_next = S_DLV;
      end
      S_DLV: begin
        emit                  = 1'b1;
        emit_item.kind        = KIND_READ;
        emit_item.data        = rdata;
        emit_item.read_length = 6'(len);
        emit_item.last        = (rd_inc == len);
        if (load) begin
          if (rd_inc == len) begin
            state_next = S_IDLE;
          end else begin
            rd_idx_next = rd_inc;
            re          = 1'b1;
            raddr       = rd_inc[AW-1:0];
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    len       <= len_next;
    rd_idx    <= rd_idx_next;
    byte_q    <= byte_q_next;
    echo_idx  <= echo_idx_next;
    echo_last <= echo_last_next;
    erase     <= erase_next;
    raw       <= raw_next;
    dlv       <= dlv_next;
    if (load) begin
      result <= emit_item;
    end
  end

endmodule

/* src/console_line_discipline.sv */
// Console line discipline top level: APB register block and line sequencer.
//
//   channel   dir  handshake                    payload
//   item      in   item_valid / item_ready      in_item_t  (op, rx_byte, read_limit)
//   result    out  result_valid / result_ready  out_item_t (kind, data, read_length, last)
//   apb       in   psel / penable / pready      paddr, pwdata, prdata
//
// One item at a time: it is accepted in S_IDLE, then one result per cycle goes through
// the output register unless stalled; S_RD starts the RAM read of a delivered line.
// Synchronous reset clears the fill count and control; the line RAM needs no clearing.
// Stalled results hold the sequencer; item_ready is low until the last one is loaded.
module console_line_discipline
  import cld_pkg::*;
#(
  parameter int LINE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  in_item_t    item,
  output logic        result_valid,
  input  logic        result_ready,
  output out_item_t   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.echo_enable      <= 1'b1;
      cfg.canonical_enable <= 1'b1;
      cfg.signal_enable    <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ECHO:   cfg.echo_enable      <= pwdata[0];
        REG_CANON:  cfg.canonical_enable <= pwdata[0];
        REG_SIGNAL: cfg.signal_enable    <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_ECHO:   prdata[0] = cfg.echo_enable;
      REG_CANON:  prdata[0] = cfg.canonical_enable;
      REG_SIGNAL: prdata[0] = cfg.signal_enable;
      default:    prdata    = '0;
    endcase
  end

  cld_seq #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
